[rtl/aabb_mv_pkg.sv]
// ----------------------------------------------------------------------------
// aabb_mv_pkg: shared types and constants of the sliding collision mover
// Holds the item modes, the outcome codes, the controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package aabb_mv_pkg;

  localparam int MAX_OBSTACLES_DEF = 64;
  localparam int FRAC_BITS_DEF     = 8;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_MOVE   = 2'd2;
  localparam logic [1:0] MODE_PLACE  = 2'd3;

  localparam logic [2:0] OUT_FULL    = 3'd0;
  localparam logic [2:0] OUT_XSLIDE  = 3'd1;
  localparam logic [2:0] OUT_YSLIDE  = 3'd2;
  localparam logic [2:0] OUT_BLOCKED = 3'd3;
  localparam logic [2:0] OUT_UPDATED = 3'd4;
  localparam logic [2:0] OUT_TFULL   = 3'd5;

  localparam logic [2:0] REG_SPEED = 3'd0;
  localparam logic [2:0] REG_OFFX  = 3'd1;
  localparam logic [2:0] REG_OFFY  = 3'd2;
  localparam logic [2:0] REG_WID   = 3'd3;
  localparam logic [2:0] REG_HGT   = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQRT,
    ST_MUL,
    ST_DIVX,
    ST_DIVY,
    ST_CAND,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture the request
    logic simple;    // execute a clear, append or place and raise the result
    logic sqrt_go;   // one square root step
    logic mul_go;    // form the step numerator
    logic divx_go;   // one divide step, x component
    logic divy_go;   // one divide step, y component
    logic cand;      // form the candidate positions
    logic scan_go;   // read the next obstacle and accumulate
    logic decide;    // pick the candidate and raise the result
    logic cnt_clr;   // clear the step counter
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [1:0] mode;
    logic       sqrt_last;
    logic       div_last;
    logic       scan_last;
  } stat_t;

endpackage

[rtl/aabb_slide_collision_mover_core.sv]
// ----------------------------------------------------------------------------
// aabb_slide_collision_mover_core: sliding AABB collision mover
// Channel  | signals                                  | handshake
// request  | mode, dir_*, elapsed, obj_*, place_*     | start, taken when !busy
// result   | pos_x, pos_y, outcome, old_area          | done, one cycle
// config   | cfg_we, cfg_index, cfg_data              | written when cfg_we
// A table item keeps busy high for one cycle after the accepting edge; a move
// keeps it high through the 17-step square root, two 52-step dividers and
// the scan, which reads one obstacle from the memory port a cycle. The done
// strobe comes in the first cycle with busy low, and a new request may be
// taken in that cycle. Reset is synchronous; the receiver cannot stall
// results.
// ----------------------------------------------------------------------------
module aabb_slide_collision_mover_core
  import aabb_mv_pkg::*;
#(
  parameter int MAX_OBSTACLES = MAX_OBSTACLES_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [19:0]        cfg_data,
  input  logic [1:0]         mode,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic [15:0]        elapsed,
  input  logic signed [15:0] obj_left,
  input  logic signed [15:0] obj_top,
  input  logic [11:0]        obj_width,
  input  logic [11:0]        obj_height,
  input  logic signed [23:0] place_x,
  input  logic signed [23:0] place_y,
  output logic               done,
  output logic signed [23:0] pos_x,
  output logic signed [23:0] pos_y,
  output logic [2:0]         outcome,
  output logic [31:0]        old_area
);

  cmd_t  cmd;
  stat_t stat;

  aabb_mv_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat), .busy(busy), .cmd(cmd)
  );

  aabb_mv_dp #(.MAX_OBSTACLES(MAX_OBSTACLES), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mode(mode), .dir_x(dir_x), .dir_y(dir_y), .elapsed(elapsed),
    .obj_left(obj_left), .obj_top(obj_top), .obj_width(obj_width),
    .obj_height(obj_height), .place_x(place_x), .place_y(place_y),
    .done(done), .pos_x(pos_x), .pos_y(pos_y), .outcome(outcome),
    .old_area(old_area)
  );

`ifndef SYNTHESIS
  // A result only appears while a request is being served
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without a request");
  // A non-move result never reports an area
  a_area_zero: assert property (@(posedge clk) disable iff (rst)
    done && (outcome == OUT_UPDATED || outcome == OUT_TFULL) |-> old_area == 0)
    else $error("area on a table result");
  // Outcome codes stay in range
  a_outcome: assert property (@(posedge clk) disable iff (rst)
    done |-> outcome <= OUT_TFULL) else $error("bad outcome");
`endif

endmodule

[rtl/aabb_mv_ctrl.sv]
// ----------------------------------------------------------------------------
// aabb_mv_ctrl: controller of the sliding collision mover
// Sequences the square root, the step division and the obstacle scan.
// ----------------------------------------------------------------------------
module aabb_mv_ctrl
  import aabb_mv_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output logic  busy,
  output cmd_t  cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_DONE; else state_next = ST_IDLE;
      ST_DONE:  state_next = (stat.mode == MODE_MOVE) ? ST_SQRT : ST_IDLE;
      ST_SQRT:  if (stat.sqrt_last) state_next = ST_MUL;
      ST_MUL:   state_next = ST_DIVX;
      ST_DIVX:  if (stat.div_last) state_next = ST_DIVY;
      ST_DIVY:  if (stat.div_last) state_next = ST_CAND;
      ST_CAND:  state_next = ST_SCAN;
      ST_SCAN:  if (stat.scan_last) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE:  begin cmd.load = start; cmd.cnt_clr = 1'b1; end
      ST_DONE:  begin cmd.simple = (stat.mode != MODE_MOVE); cmd.cnt_clr = 1'b1; end
      ST_SQRT:  begin cmd.sqrt_go = 1'b1; cmd.cnt_clr = stat.sqrt_last; end
      ST_MUL:   begin cmd.mul_go = 1'b1; cmd.cnt_clr = 1'b1; end
      ST_DIVX:  begin cmd.divx_go = 1'b1; cmd.cnt_clr = stat.div_last; end
      ST_DIVY:  begin cmd.divy_go = 1'b1; cmd.cnt_clr = stat.div_last; end
      ST_CAND:  cmd.cand = 1'b1;
      ST_SCAN:  cmd.scan_go = 1'b1;
      ST_DRAIN: cmd.decide = 1'b1;
      default:  cmd = '0;
    endcase
  end

endmodule

[rtl/aabb_mv_dp.sv]
// ----------------------------------------------------------------------------
// aabb_mv_dp: datapath of the sliding collision mover
// Square root and restoring divider units, the obstacle memory and four
// overlap accumulators that the scan updates together.
// ----------------------------------------------------------------------------
module aabb_mv_dp
  import aabb_mv_pkg::*;
#(
  parameter int MAX_OBSTACLES = MAX_OBSTACLES_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [19:0]        cfg_data,
  input  logic [1:0]         mode,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic [15:0]        elapsed,
  input  logic signed [15:0] obj_left,
  input  logic signed [15:0] obj_top,
  input  logic [11:0]        obj_width,
  input  logic [11:0]        obj_height,
  input  logic signed [23:0] place_x,
  input  logic signed [23:0] place_y,
  output logic               done,
  output logic signed [23:0] pos_x,
  output logic signed [23:0] pos_y,
  output logic [2:0]         outcome,
  output logic [31:0]        old_area
);

  localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int CW = $clog2(MAX_OBSTACLES + 1);

  // Configuration registers
  logic [19:0]        move_speed;
  logic signed [11:0] off_x, off_y;
  logic [11:0]        hb_w, hb_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      move_speed <= '0; off_x <= '0; off_y <= '0; hb_w <= '0; hb_h <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPEED: move_speed <= cfg_data;
        REG_OFFX:  off_x <= cfg_data[11:0];
        REG_OFFY:  off_y <= cfg_data[11:0];
        REG_WID:   hb_w <= cfg_data[11:0];
        REG_HGT:   hb_h <= cfg_data[11:0];
        default:   ;
      endcase
    end
  end

  // Captured request
  logic [1:0]         r_mode;
  logic signed [15:0] r_dx, r_dy;
  logic [15:0]        r_dt;
  logic signed [15:0] r_left, r_top;
  logic [11:0]        r_w, r_h;
  logic signed [23:0] r_px, r_py;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_mode <= mode; r_dx <= dir_x; r_dy <= dir_y; r_dt <= elapsed;
      r_left <= obj_left; r_top <= obj_top; r_w <= obj_width; r_h <= obj_height;
      r_px <= place_x; r_py <= place_y;
    end
  end
  assign stat.mode = r_mode;

  // Shared step counter
  logic [5:0] cnt;
  always_ff @(posedge clk) begin
    if (cmd.cnt_clr) cnt <= '0;
    else             cnt <= cnt + 6'd1;
  end

  // Entity state, obstacle count and obstacle memory
  logic signed [23:0] ent_x, ent_y;
  logic [CW-1:0]      ocount;
  logic [55:0]        omem [MAX_OBSTACLES];
  logic [55:0]        ord;
  logic [CW-1:0]      ridx;
  logic               full;
  assign full = (ocount == CW'(MAX_OBSTACLES));

  always_ff @(posedge clk) begin
    if (cmd.simple && r_mode == MODE_APPEND && !full) begin
      omem[ocount[AW-1:0]] <= {r_left, r_top, r_w, r_h};
    end
    ord <= omem[ridx[AW-1:0]];
  end

  // Square root, one result bit a step over the 33 bit sum of squares
  logic [32:0] sq_n;
  logic [16:0] sq_r;
  logic [16:0] sq_bit;
  assign sq_bit   = 17'd1 << (5'd16 - cnt[4:0]);
  assign stat.sqrt_last = (cnt == 6'd16);

  // Square root by trial: is (r|bit)^2 <= n ; kept simple as one narrow mult
  logic [16:0] sq_cand;
  logic [33:0] sq_csq;
  assign sq_cand = sq_r | sq_bit;
  assign sq_csq  = sq_cand * sq_cand;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sq_n <= 33'(32'(dir_x * dir_x)) + 33'(32'(dir_y * dir_y));
      sq_r <= '0;
    end else if (cmd.sqrt_go) begin
      if (sq_csq <= 34'(sq_n)) sq_r <= sq_cand;
    end
  end

  // Numerator speed*dt, then divided by len<<16 for each component
  logic [35:0] sdt;
  logic [15:0] mag_x, mag_y;
  assign mag_x = r_dx[15] ? 16'(-r_dx) : r_dx;
  assign mag_y = r_dy[15] ? 16'(-r_dy) : r_dy;

  always_ff @(posedge clk) begin
    if (cmd.mul_go) sdt <= move_speed * r_dt;
  end

  // Restoring divider: (mag*sdt) / (len<<16); quotient below 2^36.
  // The dividend bits come straight from the product of the component.
  logic [51:0] prod_x, prod_y;
  assign prod_x = mag_x * sdt;
  assign prod_y = mag_y * sdt;

  logic [51:0] dv_src;
  logic [51:0] dv_quo;
  logic [52:0] dv_rem;
  logic [52:0] dv_try;
  logic [32:0] dv_den;
  logic [5:0]  dv_i;
  logic signed [24:0] step_x, step_y;
  assign dv_src = cmd.divy_go ? prod_y : prod_x;
  assign dv_den = {sq_r[15:0], 17'd0} >> 1;
  assign dv_i   = 6'd51 - cnt;
  assign dv_try = {dv_rem[51:0], dv_src[dv_i]};
  assign stat.div_last = (cnt == 6'd51);

  logic [52:0] dv_rem_n;
  logic        dv_bit;
  always_comb begin
    dv_bit   = (dv_try >= 53'(dv_den));
    dv_rem_n = dv_bit ? dv_try - 53'(dv_den) : dv_try;
  end

  function automatic logic signed [24:0] sat_step(input logic [51:0] q, input logic neg);
    logic [24:0] m;
    m = (q > 52'd16777215) ? 25'd16777215 : q[24:0];
    return neg ? -$signed(m) : $signed(m);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.mul_go || (cmd.divx_go && stat.div_last)) begin
      dv_rem <= '0; dv_quo <= '0;
    end else if (cmd.divx_go || cmd.divy_go) begin
      dv_rem <= dv_rem_n; dv_quo <= {dv_quo[50:0], dv_bit};
    end
    if (cmd.divx_go && stat.div_last)
      step_x <= (sq_r == 0) ? '0 : sat_step({dv_quo[50:0], dv_bit}, r_dx[15]);
    if (cmd.divy_go && stat.div_last)
      step_y <= (sq_r == 0) ? '0 : sat_step({dv_quo[50:0], dv_bit}, r_dy[15]);
  end

  // Candidate positions and hitbox corners
  function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
    if (v > 26'sd8388607)  return 24'sh7FFFFF;
    if (v < -26'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  // Whole pixels, truncated toward zero; the magnitude is kept unsigned so
  // that the most negative position divides correctly.
  function automatic logic signed [24:0] pix(input logic signed [23:0] p);
    logic [23:0] a;
    a = p[23] ? 24'(-p) : 24'(p);
    a = a >> FRAC_BITS;
    return p[23] ? -$signed({1'b0, a}) : $signed({1'b0, a});
  endfunction

  logic signed [23:0] fx, fy;
  logic signed [25:0] hx0 [2], hy0 [2];

  always_ff @(posedge clk) begin
    if (cmd.cand) begin
      fx <= sat24(26'(ent_x) + 26'(step_x));
      fy <= sat24(26'(ent_y) + 26'(step_y));
    end
  end

  always_comb begin
    hx0[0] = 26'(pix(ent_x)) + 26'(off_x);
    hx0[1] = 26'(pix(fx)) + 26'(off_x);
    hy0[0] = 26'(pix(ent_y)) + 26'(off_y);
    hy0[1] = 26'(pix(fy)) + 26'(off_y);
  end

  // Scan: address, valid of the registered read, and four accumulators
  logic        rd_vld;
  logic [63:0] acc [4];
  assign stat.scan_last = (ridx >= ocount);

  function automatic logic [23:0] ovl(input logic signed [25:0] a0,
                                      input logic [11:0] aw,
                                      input logic signed [15:0] b0,
                                      input logic [11:0] bw);
    logic signed [26:0] lo, hi, a1, b1;
    a1 = 27'(a0) + 27'(aw);
    b1 = 27'(b0) + 27'(bw);
    lo = (27'(a0) > 27'(b0)) ? 27'(a0) : 27'(b0);
    hi = (a1 < b1) ? a1 : b1;
    return (hi > lo) ? 24'(hi - lo) : 24'd0;
  endfunction

  logic [23:0] ox [2], oy [2];
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      ox[k] = ovl(hx0[k], hb_w, $signed(ord[55:40]), ord[23:12]);
      oy[k] = ovl(hy0[k], hb_h, $signed(ord[39:24]), ord[11:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cand) begin
      ridx <= '0; rd_vld <= 1'b0;
      for (int k = 0; k < 4; k++) acc[k] <= '0;
    end else if (cmd.scan_go || cmd.decide) begin
      if (cmd.scan_go && !stat.scan_last) ridx <= ridx + 1'b1;
      rd_vld <= cmd.scan_go && !stat.scan_last;
      if (rd_vld) begin
        acc[0] <= acc[0] + 64'(ox[0][12:0] * oy[0][12:0]);
        acc[1] <= acc[1] + 64'(ox[1][12:0] * oy[1][12:0]);
        acc[2] <= acc[2] + 64'(ox[1][12:0] * oy[0][12:0]);
        acc[3] <= acc[3] + 64'(ox[0][12:0] * oy[1][12:0]);
      end
    end
  end

  // State update and result
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_x <= '0; ent_y <= '0; ocount <= '0; done <= 1'b0;
    end else begin
      done <= cmd.simple || (cmd.decide && rd_vld);
      if (cmd.simple) begin
        old_area <= '0;
        outcome  <= OUT_UPDATED;
        pos_x <= ent_x; pos_y <= ent_y;
        unique case (r_mode)
          MODE_CLEAR: ocount <= '0;
          MODE_APPEND: begin
            if (full) outcome <= OUT_TFULL;
            else ocount <= ocount + 1'b1;
          end
          MODE_PLACE: begin
            ent_x <= r_px; ent_y <= r_py; pos_x <= r_px; pos_y <= r_py;
          end
          default: ;
        endcase
      end else if (cmd.decide && !rd_vld) begin
        old_area <= (acc[0][63:32] != 0) ? 32'hFFFFFFFF : acc[0][31:0];
        pos_x <= ent_x; pos_y <= ent_y;
        if (acc[1] <= acc[0]) begin
          ent_x <= fx; ent_y <= fy; pos_x <= fx; pos_y <= fy; outcome <= OUT_FULL;
        end else if (acc[2] <= acc[0]) begin
          ent_x <= fx; pos_x <= fx; outcome <= OUT_XSLIDE;
        end else if (acc[3] <= acc[0]) begin
          ent_y <= fy; pos_y <= fy; outcome <= OUT_YSLIDE;
        end else begin
          outcome <= OUT_BLOCKED;
        end
        done <= 1'b1;
      end
    end
  end

endmodule

[dv/aabb_slide_collision_mover_core_tb.sv]
// ----------------------------------------------------------------------------
// aabb_slide_collision_mover_core_tb: self-checking bench of the slide mover
// Drives clear, append, place and move requests in random bursts with random
// gaps. An internal predictor of the mover works out each result, and every
// done strobe is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module aabb_slide_collision_mover_core_tb;
  import aabb_mv_pkg::*;

  localparam int NOBS = MAX_OBSTACLES_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam longint POS_LO = -64'sd8388608;
  localparam longint POS_HI = 64'sd8388607;
  localparam int N_RANDOM = 1650;
  localparam longint CYCLE_LIMIT = 64'd3000000;

  // One request to the block
  typedef struct {
    logic [1:0] md;
    logic signed [15:0] dx, dy;
    logic [15:0] dt;
    logic signed [15:0] ol, ot;
    logic [11:0] ow, oh;
    logic signed [23:0] px, py;
  } req_t;

  // One result of the block
  typedef struct packed {
    logic signed [23:0] x, y;
    logic [2:0] oc;
    logic [31:0] area;
  } res_t;

  // Directed row: a request plus an optional typed-in result
  typedef struct {
    req_t r;
    bit known;
    res_t want;
  } row_t;

  logic clk, rst, start, busy, cfg_we, done;
  logic [2:0] cfg_index;
  logic [19:0] cfg_data;
  logic [1:0] mode;
  logic signed [15:0] dir_x, dir_y, obj_left, obj_top;
  logic [15:0] elapsed;
  logic [11:0] obj_width, obj_height;
  logic signed [23:0] place_x, place_y, pos_x, pos_y;
  logic [2:0] outcome;
  logic [31:0] old_area;

  aabb_slide_collision_mover_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mode(mode), .dir_x(dir_x), .dir_y(dir_y), .elapsed(elapsed),
    .obj_left(obj_left), .obj_top(obj_top), .obj_width(obj_width),
    .obj_height(obj_height), .place_x(place_x), .place_y(place_y),
    .done(done), .pos_x(pos_x), .pos_y(pos_y), .outcome(outcome),
    .old_area(old_area)
  );

  // Predictor state and register copies
  longint spd, hb_ox, hb_oy, hb_w, hb_h;
  longint ent_x, ent_y;
  longint obs_l[NOBS], obs_t[NOBS], obs_w[NOBS], obs_h[NOBS];
  int obs_n;

  res_t pending_q[$];
  int errors;
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result checker
  always @(posedge clk) begin
    res_t w;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        $display("%0t: result with no request pending", $time);
        errors++;
      end else begin
        w = pending_q.pop_front();
        if (pos_x !== w.x) begin
          $display("%0t: pos_x expected %0d got %0d", $time, w.x, pos_x);
          errors++;
        end
        if (pos_y !== w.y) begin
          $display("%0t: pos_y expected %0d got %0d", $time, w.y, pos_y);
          errors++;
        end
        if (outcome !== w.oc) begin
          $display("%0t: outcome expected %0d got %0d", $time, w.oc, outcome);
          errors++;
        end
        if (old_area !== w.area) begin
          $display("%0t: old_area expected %0d got %0d", $time, w.area, old_area);
          errors++;
        end
      end
    end
  end

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // Whole-pixel position, truncated toward zero
  function automatic longint pix(longint p);
    return p / (64'sd1 << FB);
  endfunction

  function automatic longint clamp_pos(longint p);
    if (p < POS_LO) return POS_LO;
    if (p > POS_HI) return POS_HI;
    return p;
  endfunction

  // Summed overlap of the hitbox with every stored obstacle
  function automatic longint unsigned overlap_sum(longint px, longint py);
    longint ax0, ay0, ax1, ay1, x0, y0, x1, y1;
    longint unsigned s;
    s = 0;
    ax0 = pix(px) + hb_ox;
    ay0 = pix(py) + hb_oy;
    ax1 = ax0 + hb_w;
    ay1 = ay0 + hb_h;
    for (int i = 0; i < obs_n; i++) begin
      x0 = ax0 > obs_l[i] ? ax0 : obs_l[i];
      y0 = ay0 > obs_t[i] ? ay0 : obs_t[i];
      x1 = ax1 < obs_l[i] + obs_w[i] ? ax1 : obs_l[i] + obs_w[i];
      y1 = ay1 < obs_t[i] + obs_h[i] ? ay1 : obs_t[i] + obs_h[i];
      if (x1 > x0 && y1 > y0) s += longint'(x1 - x0) * longint'(y1 - y0);
    end
    return s;
  endfunction

  function automatic longint step_part(longint d, longint len, longint dt);
    longint unsigned mag, q;
    mag = d < 0 ? -d : d;
    q = (mag * longint'(spd) * dt) / (longint'(len) << 16);
    return d < 0 ? -longint'(q) : longint'(q);
  endfunction

  // Work out the result of one request and update the predicted state
  function automatic res_t predict_mover(req_t r);
    res_t o;
    longint dx, dy, len, sx, sy, fx, fy;
    longint unsigned a_old, a_full, a_x, a_y;
    o.oc = OUT_UPDATED;
    o.area = 0;
    case (r.md)
      MODE_CLEAR: obs_n = 0;
      MODE_APPEND: begin
        if (obs_n < NOBS) begin
          obs_l[obs_n] = longint'(r.ol);
          obs_t[obs_n] = longint'(r.ot);
          obs_w[obs_n] = longint'(r.ow);
          obs_h[obs_n] = longint'(r.oh);
          obs_n++;
        end else begin
          o.oc = OUT_TFULL;
        end
      end
      MODE_PLACE: begin
        ent_x = longint'(r.px);
        ent_y = longint'(r.py);
      end
      default: begin
        dx = longint'(r.dx);
        dy = longint'(r.dy);
        len = int_sqrt(dx * dx + dy * dy);
        sx = 0;
        sy = 0;
        if (len != 0) begin
          sx = step_part(dx, len, longint'(r.dt));
          sy = step_part(dy, len, longint'(r.dt));
        end
        fx = clamp_pos(ent_x + sx);
        fy = clamp_pos(ent_y + sy);
        a_old = overlap_sum(ent_x, ent_y);
        a_full = overlap_sum(fx, fy);
        a_x = overlap_sum(fx, ent_y);
        a_y = overlap_sum(ent_x, fy);
        if (a_full <= a_old) begin
          ent_x = fx;
          ent_y = fy;
          o.oc = OUT_FULL;
        end else if (a_x <= a_old) begin
          ent_x = fx;
          o.oc = OUT_XSLIDE;
        end else if (a_y <= a_old) begin
          ent_y = fy;
          o.oc = OUT_YSLIDE;
        end else begin
          o.oc = OUT_BLOCKED;
        end
        o.area = a_old > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : a_old[31:0];
      end
    endcase
    o.x = ent_x[23:0];
    o.y = ent_y[23:0];
    return o;
  endfunction

  // Register write, only while the block is idle
  task automatic write_reg(logic [2:0] idx, logic [19:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_SPEED: spd = longint'(val);
      REG_OFFX: hb_ox = longint'(signed'(val[11:0]));
      REG_OFFY: hb_oy = longint'(signed'(val[11:0]));
      REG_WID: hb_w = longint'(val[11:0]);
      REG_HGT: hb_h = longint'(val[11:0]);
      default: ;
    endcase
  endtask

  // Issue one request at the falling edge and hold start until accepted
  task automatic send_request(req_t r, bit known, res_t want);
    res_t p;
    @(negedge clk);
    start = 1'b1;
    mode = r.md;
    dir_x = r.dx;
    dir_y = r.dy;
    elapsed = r.dt;
    obj_left = r.ol;
    obj_top = r.ot;
    obj_width = r.ow;
    obj_height = r.oh;
    place_x = r.px;
    place_y = r.py;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = predict_mover(r);
    if (known && p != want) begin
      $display("%0t: predictor expected %0d/%0d/%0d/%0d typed %0d/%0d/%0d/%0d",
               $time, p.x, p.y, p.oc, p.area, want.x, want.y, want.oc, want.area);
      errors++;
    end
    pending_q.push_back(known ? want : p);
    @(negedge clk);
    start = 1'b0;
  endtask

  // Wait until every result is in, then let the block settle
  task automatic drain_results();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic req_t blank_req(logic [1:0] md);
    req_t r;
    r.md = md;
    r.dx = 0; r.dy = 0; r.dt = 0;
    r.ol = 0; r.ot = 0; r.ow = 0; r.oh = 0;
    r.px = 0; r.py = 0;
    return r;
  endfunction

  function automatic req_t random_req();
    req_t r;
    int pick;
    r = blank_req(MODE_MOVE);
    r.dx = 16'($urandom); r.dy = 16'($urandom); r.dt = 16'($urandom);
    r.ol = 16'($urandom); r.ot = 16'($urandom);
    r.ow = 12'($urandom); r.oh = 12'($urandom);
    r.px = 24'($urandom); r.py = 24'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 3) r.md = MODE_CLEAR;
    else if (pick < 25) r.md = MODE_APPEND;
    else if (pick < 32) r.md = MODE_PLACE;
    // Keep most geometry near the entity so that overlaps actually happen
    if ($urandom_range(0, 9) < 8) begin
      r.ol = 16'($signed($urandom_range(0, 400)) - 200);
      r.ot = 16'($signed($urandom_range(0, 400)) - 200);
      r.ow = 12'($urandom_range(0, 80));
      r.oh = 12'($urandom_range(0, 80));
      r.px = 24'(($signed($urandom_range(0, 300)) - 150) * 256 + $urandom_range(0, 255));
      r.py = 24'(($signed($urandom_range(0, 300)) - 150) * 256 + $urandom_range(0, 255));
      r.dt = 16'($urandom_range(0, 8000));
    end
    if ($urandom_range(0, 19) == 0) begin
      r.dx = 0;
      r.dy = 0;
    end
    return r;
  endfunction

  task automatic random_config();
    write_reg(REG_SPEED,
              $urandom_range(0, 9) == 0 ? 20'hFFFFF : 20'($urandom_range(0, 60000)));
    write_reg(REG_OFFX, 20'($urandom_range(0, 40) - 20));
    write_reg(REG_OFFY, 20'($urandom_range(0, 40) - 20));
    write_reg(REG_WID, 20'($urandom_range(0, 60)));
    write_reg(REG_HGT, 20'($urandom_range(0, 60)));
  endtask

  row_t dir_rows[$];

  // Directed rows: reset state, extremes, every mode and the special cases
  task automatic build_directed();
    row_t w;
    req_t r;
    // Move straight after reset: nothing stored, entity at the origin
    r = blank_req(MODE_MOVE); r.dx = 100; r.dt = 1000;
    w.r = r; w.known = 1; w.want = '{24'sd0, 24'sd0, OUT_FULL, 32'd0};
    dir_rows.push_back(w);
    r = blank_req(MODE_PLACE); r.px = 24'sh7FFFFF; r.py = 24'sh800000;
    w.r = r; w.want = '{24'sh7FFFFF, 24'sh800000, OUT_UPDATED, 32'd0};
    dir_rows.push_back(w);
    w.known = 0;
    r = blank_req(MODE_CLEAR); w.r = r; dir_rows.push_back(w);
    r = blank_req(MODE_PLACE); r.px = 24'sh000180; r.py = -24'sh000180;
    w.r = r; dir_rows.push_back(w);
    r = blank_req(MODE_APPEND); r.ol = 16'sh8000; r.ot = 16'sh7FFF;
    r.ow = 12'hFFF; r.oh = 12'hFFF; w.r = r; dir_rows.push_back(w);
    r = blank_req(MODE_APPEND); r.ol = -5; r.ot = -8; r.ow = 12; r.oh = 10;
    w.r = r; dir_rows.push_back(w);
    r = blank_req(MODE_APPEND); r.ol = 20; r.ot = -40; r.ow = 0; r.oh = 50;
    w.r = r; dir_rows.push_back(w);
    r = blank_req(MODE_APPEND); r.ol = 2; r.ot = -60; r.ow = 30; r.oh = 40;
    w.r = r; dir_rows.push_back(w);
    // Moves: each direction extreme, zero direction, saturating steps
    r = blank_req(MODE_MOVE); r.dx = 16'sh7FFF; r.dy = 0; r.dt = 16'hFFFF;
    w.r = r; dir_rows.push_back(w);
    r = blank_req(MODE_MOVE); r.dx = 16'sh8000; r.dy = 16'sh8000; r.dt = 16'hFFFF;
    w.r = r; dir_rows.push_back(w);
    r = blank_req(MODE_MOVE); r.dx = 0; r.dy = 0; r.dt = 16'hFFFF;
    w.r = r; dir_rows.push_back(w);
    r = blank_req(MODE_MOVE); r.dx = 3; r.dy = -4; r.dt = 3000;
    w.r = r; dir_rows.push_back(w);
    r = blank_req(MODE_MOVE); r.dx = -1; r.dy = 16'sh7FFF; r.dt = 500;
    w.r = r; dir_rows.push_back(w);
    r = blank_req(MODE_MOVE); r.dx = 16'sh7FFF; r.dy = 16'sh7FFF; r.dt = 16'hFFFF;
    w.r = r; dir_rows.push_back(w);
    r = blank_req(MODE_PLACE); r.px = -24'sh000200; r.py = 24'sh000100;
    w.r = r; dir_rows.push_back(w);
    r = blank_req(MODE_MOVE); r.dx = 10; r.dy = 10; r.dt = 2000;
    w.r = r; dir_rows.push_back(w);
    r = blank_req(MODE_MOVE); r.dx = -10; r.dy = 3; r.dt = 9000;
    w.r = r; dir_rows.push_back(w);
  endtask

  initial begin
    req_t r;
    res_t none;
    int burst;
    errors = 0;
    cycles = 0;
    none = '{24'sd0, 24'sd0, 3'd0, 32'd0};
    rst = 1'b1;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mode = MODE_CLEAR;
    dir_x = 0; dir_y = 0; elapsed = 0;
    obj_left = 0; obj_top = 0; obj_width = 0; obj_height = 0;
    place_x = 0; place_y = 0;
    spd = 0; hb_ox = 0; hb_oy = 0; hb_w = 0; hb_h = 0;
    ent_x = 0; ent_y = 0; obs_n = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // First request runs at reset register values
    build_directed();
    send_request(dir_rows[0].r, dir_rows[0].known, dir_rows[0].want);
    drain_results();
    write_reg(REG_SPEED, 20'hFFFFF);
    write_reg(REG_OFFX, 20'h00800);
    write_reg(REG_OFFY, 20'h007FF);
    write_reg(REG_WID, 20'h00FFF);
    write_reg(REG_HGT, 20'h00FFF);
    for (int i = 1; i < dir_rows.size(); i++) begin
      if (i == 3) begin
        drain_results();
        write_reg(REG_SPEED, 20'd40000);
        write_reg(REG_OFFX, -20'sd3);
        write_reg(REG_OFFY, -20'sd2);
        write_reg(REG_WID, 20'd6);
        write_reg(REG_HGT, 20'd5);
      end
      send_request(dir_rows[i].r, dir_rows[i].known, dir_rows[i].want);
    end

    // Fill the table to the brim and beyond so the full case shows
    drain_results();
    random_config();
    for (int i = 0; i < NOBS + 3; i++) begin
      r = random_req();
      r.md = MODE_APPEND;
      send_request(r, 0, none);
    end
    r = random_req();
    r.md = MODE_MOVE;
    send_request(r, 0, none);
    r.md = MODE_CLEAR;
    send_request(r, 0, none);

    // Random phases in bursts, with a new register setting between phases
    for (int n = 0; n < N_RANDOM; ) begin
      if (n % 300 == 0) begin
        drain_results();
        random_config();
      end
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst; k++) begin
        send_request(random_req(), 0, none);
        n++;
      end
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 40)) @(posedge clk);
      else if ($urandom_range(0, 9) == 0) begin
        while (pending_q.size() != 0) @(posedge clk);
      end
    end

    drain_results();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
rtl/aabb_mv_pkg.sv
rtl/aabb_mv_ctrl.sv
rtl/aabb_mv_dp.sv
rtl/aabb_slide_collision_mover_core.sv
dv/aabb_slide_collision_mover_core_tb.sv
